[hw/rtl/crc_pkg.sv]
`timescale 1ns / 1ps
package crc_pkg;

  localparam int W          = 32;
  localparam int FRAC_BITS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int CNT_W      = COUNT_BITS + 1;
  localparam int PROD_W     = 2 * W;
  localparam int REM_W      = W + COUNT_BITS;
  localparam int QUO_W      = W;
  localparam int DSH_W      = W + QUO_W - 1;

  typedef logic signed [W-1:0] fix_t;

  localparam fix_t SCALE_ONE = W'(1 << FRAC_BITS);

  typedef enum logic [0:0] {
    REG_SCALE  = 1'b0,
    REG_OFFSET = 1'b1
  } reg_idx_t;

  typedef struct packed {
    fix_t                  lo;
    fix_t                  hi;
    fix_t                  xmin;
    fix_t                  xmax;
    logic [COUNT_BITS-1:0] n;
    logic [W-1:0]          d;
    logic                  act;
    logic                  from_lo;
    logic                  need_lo;
    logic                  need_hi;
    logic [COUNT_BITS-1:0] cut_lo;
    logic [COUNT_BITS-1:0] cut_hi;
  } ctx_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DSH_W-1:0] dsh;
    logic [QUO_W-1:0] quo;
  } lane_t;

  function automatic fix_t sat_w(input logic signed [PROD_W-1:0] v);
    fix_t r;
    if (!v[PROD_W-1] && (|v[PROD_W-2:W-1])) begin
      r = {1'b0, {(W-1){1'b1}}};
    end else if (v[PROD_W-1] && !(&v[PROD_W-2:W-1])) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/crc_if.sv]
`timescale 1ns / 1ps
interface crc_in_if;
  import crc_pkg::*;

  logic                  valid;
  logic                  ready;
  fix_t                  edge_first;
  fix_t                  edge_last;
  fix_t                  clip_low;
  fix_t                  clip_high;
  logic [COUNT_BITS-1:0] cell_count;

  modport source(output valid, edge_first, edge_last, clip_low, clip_high, cell_count,
                 input ready);
  modport sink(input valid, edge_first, edge_last, clip_low, clip_high, cell_count,
               output ready);
endinterface

interface crc_out_if;
  import crc_pkg::*;

  logic                     valid;
  logic                     ready;
  fix_t                     dev_first;
  fix_t                     dev_last;
  logic [COUNT_BITS-1:0]    first_cell;
  logic signed [CNT_W-1:0]  visible_count;

  modport source(output valid, dev_first, dev_last, first_cell, visible_count,
                 input ready);
  modport sink(input valid, dev_first, dev_last, first_cell, visible_count,
               output ready);
endinterface

[hw/rtl/crc_map.sv]
`timescale 1ns / 1ps
module crc_map (
  input  logic          clk,
  input  logic          en,
  input  crc_pkg::fix_t v,
  input  crc_pkg::fix_t scale,
  input  crc_pkg::fix_t offset,
  output crc_pkg::fix_t dev
);
  import crc_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] shifted;
  logic signed [PROD_W-1:0] sum;
  logic                     rnd;
  fix_t                     msat;

  always_comb begin
    rnd     = prod[PROD_W-1] && (|prod[FRAC_BITS-1:0]);
    shifted = (prod >>> FRAC_BITS) + $signed({{(PROD_W-1){1'b0}}, rnd});
    sum     = PROD_W'(msat) + PROD_W'(offset);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(v) * PROD_W'(scale);
      msat <= sat_w(shifted);
      dev  <= sat_w(sum);
    end
  end

endmodule

[hw/rtl/crc_div_cell.sv]
`timescale 1ns / 1ps
module crc_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  crc_pkg::ctx_t  in_ctx,
  input  crc_pkg::lane_t in_lo,
  input  crc_pkg::lane_t in_hi,
  output logic           out_valid,
  output crc_pkg::ctx_t  out_ctx,
  output crc_pkg::lane_t out_lo,
  output crc_pkg::lane_t out_hi
);
  import crc_pkg::*;

  // one restoring quotient bit, divisor shifts right along the row
  function automatic lane_t step(input lane_t l);
    logic  ge;
    lane_t r;
    ge    = {{(DSH_W-REM_W){1'b0}}, l.rem} >= l.dsh;
    r.rem = ge ? l.rem - l.dsh[REM_W-1:0] : l.rem;
    r.dsh = l.dsh >> 1;
    r.quo = {l.quo[QUO_W-2:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctx <= in_ctx;
      out_lo  <= step(in_lo);
      out_hi  <= step(in_hi);
    end
  end

endmodule

[hw/rtl/cell_row_clip.sv]
`timescale 1ns / 1ps
// Clips a row of equal cells against an interval after mapping all coordinates to device
// space (Q16.16). One word is accepted per clock unless the pipeline holds. Each word
// goes through mapping, classify, two rows of restoring divider cells of one quotient bit
// each that find the cut cell counts and then the edge moves, and clamping.
// The whole pipeline advances together and holds while a finished word is not taken.
module cell_row_clip (
  input  logic                      clk,
  input  logic                      rst,
  crc_in_if.sink                    item_in,
  crc_out_if.source                 item_out,
  input  logic                      cfg_we,
  input  crc_pkg::reg_idx_t         cfg_index,
  input  logic [crc_pkg::W-1:0]     cfg_data
);
  import crc_pkg::*;

  fix_t map_scale;
  fix_t map_offset;
  logic en;

  assign en            = !item_out.valid || item_out.ready;
  assign item_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_scale  <= SCALE_ONE;
      map_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCALE:  map_scale  <= cfg_data;
        REG_OFFSET: map_offset <= cfg_data;
      endcase
    end
  end

  // mapping
  logic [2:0]            vm;
  logic [COUNT_BITS-1:0] nm [3];
  fix_t                  dev_p, dev_q, dev_l, dev_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= '0;
    end else if (en) begin
      vm <= {vm[1:0], item_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nm[0] <= item_in.cell_count;
      nm[1] <= nm[0];
      nm[2] <= nm[1];
    end
  end

  crc_map u_map_p (.clk, .en, .v(item_in.edge_first), .scale(map_scale),
                   .offset(map_offset), .dev(dev_p));
  crc_map u_map_q (.clk, .en, .v(item_in.edge_last), .scale(map_scale),
                   .offset(map_offset), .dev(dev_q));
  crc_map u_map_l (.clk, .en, .v(item_in.clip_low), .scale(map_scale),
                   .offset(map_offset), .dev(dev_l));
  crc_map u_map_h (.clk, .en, .v(item_in.clip_high), .scale(map_scale),
                   .offset(map_offset), .dev(dev_h));

  // classify
  fix_t     xmin_c, xmax_c, lo_c, hi_c;
  logic     up_c, dn_c;
  ctx_t     c4, c4_next;
  logic     v4;
  logic [W-1:0] e_lo4, e_hi4;

  always_comb begin
    xmin_c = (dev_l > dev_h) ? dev_h : dev_l;
    xmax_c = (dev_l > dev_h) ? dev_l : dev_h;
    up_c   = (nm[2] != '0) && (dev_p < dev_q) && (dev_q >= xmin_c) && (dev_p <= xmax_c);
    dn_c   = (nm[2] != '0) && (dev_p > dev_q) && (dev_p >= xmin_c) && (dev_q <= xmax_c);
    lo_c   = dn_c ? dev_q : dev_p;
    hi_c   = dn_c ? dev_p : dev_q;
    c4_next.lo      = lo_c;
    c4_next.hi      = hi_c;
    c4_next.xmin    = xmin_c;
    c4_next.xmax    = xmax_c;
    c4_next.n       = nm[2];
    c4_next.d       = W'(hi_c - lo_c);
    c4_next.act     = up_c || dn_c;
    c4_next.from_lo = !dn_c;
    c4_next.need_lo = (up_c || dn_c) && (lo_c < xmin_c);
    c4_next.need_hi = (up_c || dn_c) && (hi_c > xmax_c);
    c4_next.cut_lo  = '0;
    c4_next.cut_hi  = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vm[2];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4    <= c4_next;
      e_lo4 <= W'(xmin_c - lo_c);
      e_hi4 <= W'(hi_c - xmax_c);
    end
  end

  // first divider row: cut cell counts
  logic  va [QUO_W+1];
  ctx_t  ca [QUO_W+1];
  lane_t la_lo [QUO_W+1];
  lane_t la_hi [QUO_W+1];
  logic  v5;
  ctx_t  c5;
  lane_t l5_lo, l5_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c5        <= c4;
      l5_lo.rem <= c4.need_lo ? REM_W'(e_lo4) * REM_W'(c4.n) : '0;
      l5_hi.rem <= c4.need_hi ? REM_W'(e_hi4) * REM_W'(c4.n) : '0;
      l5_lo.dsh <= {c4.d, {(QUO_W-1){1'b0}}};
      l5_hi.dsh <= {c4.d, {(QUO_W-1){1'b0}}};
      l5_lo.quo <= '0;
      l5_hi.quo <= '0;
    end
  end

  assign va[0]    = v5;
  assign ca[0]    = c5;
  assign la_lo[0] = l5_lo;
  assign la_hi[0] = l5_hi;

  for (genvar i = 0; i < QUO_W; i++) begin : g_row_a
    crc_div_cell u_cell (
      .clk, .rst, .en,
      .in_valid(va[i]), .in_ctx(ca[i]), .in_lo(la_lo[i]), .in_hi(la_hi[i]),
      .out_valid(va[i+1]), .out_ctx(ca[i+1]), .out_lo(la_lo[i+1]), .out_hi(la_hi[i+1])
    );
  end

  // second divider row: edge moves
  logic  vb [QUO_W+1];
  ctx_t  cb [QUO_W+1];
  lane_t lb_lo [QUO_W+1];
  lane_t lb_hi [QUO_W+1];
  logic  v6;
  ctx_t  c6, c6_next;
  lane_t l6_lo, l6_hi;
  logic [COUNT_BITS-1:0] cut_lo_c, cut_hi_c;

  assign cut_lo_c = la_lo[QUO_W].quo[COUNT_BITS-1:0];
  assign cut_hi_c = la_hi[QUO_W].quo[COUNT_BITS-1:0];

  always_comb begin
    c6_next        = ca[QUO_W];
    c6_next.cut_lo = cut_lo_c;
    c6_next.cut_hi = cut_hi_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= va[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c6        <= c6_next;
      l6_lo.rem <= REM_W'(ca[QUO_W].d) * REM_W'(cut_lo_c);
      l6_hi.rem <= REM_W'(ca[QUO_W].d) * REM_W'(cut_hi_c);
      l6_lo.dsh <= {W'(ca[QUO_W].n), {(QUO_W-1){1'b0}}};
      l6_hi.dsh <= {W'(ca[QUO_W].n), {(QUO_W-1){1'b0}}};
      l6_lo.quo <= '0;
      l6_hi.quo <= '0;
    end
  end

  assign vb[0]    = v6;
  assign cb[0]    = c6;
  assign lb_lo[0] = l6_lo;
  assign lb_hi[0] = l6_hi;

  for (genvar i = 0; i < QUO_W; i++) begin : g_row_b
    crc_div_cell u_cell (
      .clk, .rst, .en,
      .in_valid(vb[i]), .in_ctx(cb[i]), .in_lo(lb_lo[i]), .in_hi(lb_hi[i]),
      .out_valid(vb[i+1]), .out_ctx(cb[i+1]), .out_lo(lb_lo[i+1]), .out_hi(lb_hi[i+1])
    );
  end

  // moved edges and counts
  logic                    vf;
  ctx_t                    fc;
  fix_t                    fa, fb;
  logic signed [CNT_W-1:0] fcnt;
  logic [COUNT_BITS-1:0]   ffirst;
  logic signed [W:0]       a_c, b_c;
  logic [QUO_W-1:0]        mv_lo, mv_hi;
  ctx_t                    ce;

  assign ce = cb[QUO_W];

  // an edge moves only when it lies outside the interval
  always_comb begin
    mv_lo = ce.need_lo ? lb_lo[QUO_W].quo : '0;
    mv_hi = ce.need_hi ? lb_hi[QUO_W].quo : '0;
    a_c   = $signed({ce.lo[W-1], ce.lo}) + $signed({1'b0, mv_lo});
    b_c   = $signed({ce.hi[W-1], ce.hi}) - $signed({1'b0, mv_hi});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vb[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fc     <= ce;
      fa     <= a_c[W-1:0];
      fb     <= b_c[W-1:0];
      fcnt   <= $signed({1'b0, ce.n}) - $signed({1'b0, ce.cut_lo})
                - $signed({1'b0, ce.cut_hi});
      ffirst <= ce.from_lo ? ce.cut_lo : ce.cut_hi;
    end
  end

  // clamping and output word
  logic signed [W+1:0] ax, bx, ol, oh, a_fin, b_fin;
  logic                o_valid;
  fix_t                o_first, o_last;
  logic [COUNT_BITS-1:0]   o_cell;
  logic signed [CNT_W-1:0] o_count;

  always_comb begin
    ax    = (W+2)'(fa);
    bx    = (W+2)'(fb);
    ol    = (W+2)'(fc.xmin) - ax;
    oh    = bx - (W+2)'(fc.xmax);
    a_fin = ax;
    b_fin = bx;
    if (fc.act) begin
      if (fcnt == '0) begin
        if (fa < fc.xmin) a_fin = (W+2)'(fc.xmin);
        if (fb > fc.xmax) b_fin = (W+2)'(fc.xmax);
      end else if (fcnt == CNT_W'(1) && fa < fc.xmin && fb > fc.xmax) begin
        if (oh > ol) begin
          b_fin = bx - ol;
          a_fin = (W+2)'(fc.xmin);
        end else begin
          a_fin = ax + oh;
          b_fin = (W+2)'(fc.xmax);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (en) begin
      o_valid <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_first <= fc.from_lo ? a_fin[W-1:0] : b_fin[W-1:0];
      o_last  <= fc.from_lo ? b_fin[W-1:0] : a_fin[W-1:0];
      o_cell  <= fc.act ? ffirst : '0;
      o_count <= fc.act ? fcnt : '1;
    end
  end

  assign item_out.valid         = o_valid;
  assign item_out.dev_first     = o_first;
  assign item_out.dev_last      = o_last;
  assign item_out.first_cell    = o_cell;
  assign item_out.visible_count = o_count;

`ifndef SYNTHESIS
  a_miss_first: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_count == '1 |-> o_cell == '0)
    else $error("miss word with nonzero first cell");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    vf && fc.act |-> !fcnt[CNT_W-1] && fcnt <= $signed({1'b0, fc.n}))
    else $error("cut counts exceed cell count");

  a_move_range: assert property (@(posedge clk) disable iff (rst)
    vb[QUO_W] && ce.act |-> lb_lo[QUO_W].quo <= ce.d && lb_hi[QUO_W].quo <= ce.d)
    else $error("edge move beyond row extent");
`endif

endmodule
